@@ src/stt_pkg.sv @@
// Shared types and constants for the set membership test block.
package stt_pkg;
    localparam int SET_DEPTH_DEF = 1024;
    localparam int VAL_W = 64;
    localparam int CFG_IDX_W = 8;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TABLE_MODE = 8'd0,
        REG_INVERT     = 8'd1,
        REG_RANGE_MIN  = 8'd2,
        REG_RANGE_MAX  = 8'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR
    } state_t;
endpackage

@@ src/stt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module stt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ src/set_membership_test_top.sv @@
// Top level of the set membership test block: sorted store, search and insert sequencer.
//
// The set is a sorted, duplicate-free store in one RAM. Clear, ignored operations and
// table-mode queries outside the range finish without leaving idle. A query keeps busy high
// for a binary search, each probe a RAM read state then a compare state on the registered
// read data. An add takes the same search and then, for a new element, moves each stored
// element above the insertion point up one place with a read and a write state, then writes
// the value, all bound by the single RAM port pair. Query results appear as a one-cycle
// strobe on result_valid that cannot be held off; start is taken when busy is low.
module set_membership_test_top #(
    parameter int SET_DEPTH = stt_pkg::SET_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     operation,
    input  logic signed [stt_pkg::VAL_W-1:0] value,
    output logic                           result_valid,
    output logic                           in_set,
    output logic                           set_overflowed,
    input  logic                           cfg_we,
    input  logic [stt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [stt_pkg::VAL_W-1:0]      cfg_data
);
    import stt_pkg::*;

    localparam int AW = $clog2(SET_DEPTH);
    localparam int CW = $clog2(SET_DEPTH + 1);

    state_t state_reg, state_next;
    logic table_mode_reg, invert_reg;
    logic signed [VAL_W-1:0] range_min_reg, range_max_reg;
    logic [CW-1:0] count_reg, count_next;
    logic ovf_reg, ovf_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next, idx_reg, idx_next;
    logic hit_reg, hit_next;
    logic is_add_reg, is_add_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic valid_reg, valid_next, in_set_reg, in_set_next;
    logic [CW-1:0] mid;
    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [VAL_W-1:0] ram_wdata, ram_rdata;

    stt_ram #(.WIDTH(VAL_W), .DEPTH(SET_DEPTH)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            table_mode_reg <= 1'b0;
            invert_reg     <= 1'b0;
            range_min_reg  <= '0;
            range_max_reg  <= '0;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            valid_reg <= valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TABLE_MODE: table_mode_reg <= cfg_data[0];
                    REG_INVERT:     invert_reg     <= cfg_data[0];
                    REG_RANGE_MIN:  range_min_reg  <= cfg_data;
                    REG_RANGE_MAX:  range_max_reg  <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        idx_reg    <= idx_next;
        hit_reg    <= hit_next;
        is_add_reg <= is_add_next;
        val_reg    <= val_next;
        in_set_reg <= in_set_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        idx_next    = idx_reg;
        hit_next    = hit_reg;
        is_add_next = is_add_reg;
        val_next    = val_reg;
        valid_next  = 1'b0;
        in_set_next = in_set_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg[AW-1:0];
        ram_wdata   = ram_rdata;
        ram_raddr   = mid[AW-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                lo_next     = '0;
                hi_next     = count_reg;
                hit_next    = 1'b0;
                val_next    = value;
                is_add_next = (operation == OP_ADD);
                if (start)
                begin
                    unique case (op_t'(operation))
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            ovf_next   = 1'b0;
                        end
                        OP_ADD:   state_next = ST_SRCH_RD;
                        OP_QUERY:
                        begin
                            if (table_mode_reg && (range_max_reg < range_min_reg
                                || value < range_min_reg || value > range_max_reg))
                            begin
                                valid_next  = 1'b1;
                                in_set_next = invert_reg;
                            end
                            else
                            begin
                                state_next = ST_SRCH_RD;
                            end
                        end
                        OP_NONE:  ;
                    endcase
                end
            end
            ST_SRCH_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    state_next = ST_SRCH_CMP;
                end
                else if (!is_add_reg)
                begin
                    valid_next  = 1'b1;
                    in_set_next = hit_reg ^ invert_reg;
                    state_next  = ST_IDLE;
                end
                else if (hit_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (count_reg >= CW'(SET_DEPTH))
                begin
                    ovf_next   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = count_reg;
                    state_next = ST_SHIFT_RD;
                end
            end
            ST_SRCH_CMP:
            begin
                if ($signed(ram_rdata) < val_reg)
                begin
                    lo_next = mid + CW'(1);
                end
                else
                begin
                    hi_next  = mid;
                    hit_next = (ram_rdata == val_reg);
                end
                state_next = ST_SRCH_RD;
            end
            ST_SHIFT_RD:
            begin
                ram_raddr = AW'(idx_reg - CW'(1));
                if (idx_reg > lo_reg)
                begin
                    state_next = ST_SHIFT_WR;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = lo_reg[AW-1:0];
                    ram_wdata  = val_reg;
                    count_next = count_reg + CW'(1);
                    state_next = ST_IDLE;
                end
            end
            ST_SHIFT_WR:
            begin
                ram_we     = 1'b1;
                idx_next   = idx_reg - CW'(1);
                state_next = ST_SHIFT_RD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign busy           = (state_reg != ST_IDLE);
    assign result_valid   = valid_reg;
    assign in_set         = in_set_reg;
    assign set_overflowed = ovf_reg;
endmodule
